// ===== rtl/core/nbfj_pkg.sv =====
// Shared types, constants and saturating helpers for the force/jerk block.
// No dependencies; imported by every module under rtl/core but the checker.
package nbfj_pkg;

    localparam int WORD_W    = 64;
    localparam int MASS_W    = 63;
    localparam int FRAC_BITS = 47;

    localparam logic [WORD_W-1:0] PAT_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] PAT_MIN    = 64'h8000_0000_0000_0000;
    // at or below this squared distance the inverse root pins at full scale
    localparam logic [WORD_W-1:0] TINY_LIMIT = 64'd32768;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_SRC  = 2'd1,
        KIND_SKIP = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t                 kind;
        logic                       last;
        logic [2:0][WORD_W-1:0]     pos;
        logic [2:0][WORD_W-1:0]     vel;
        logic [MASS_W-1:0]          mass;
    } q_item_t;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] s;
        s = a + b;
        if (a[WORD_W-1] == b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1])
            s = a[WORD_W-1] ? PAT_MIN : PAT_MAX;
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] sat_sub(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] s;
        s = a - b;
        if (a[WORD_W-1] != b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1])
            s = a[WORD_W-1] ? PAT_MIN : PAT_MAX;
        return s;
    endfunction

endpackage

// ===== rtl/core/nbfj_front.sv =====
// Front end: accepts stream items, tags them load / source / self-skip,
// and holds them in a two-entry queue. Depends on nbfj_pkg.
module nbfj_front
    import nbfj_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // index[15:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass[62:0], pad
    input  logic [463:0]  s_tdata,
    input  logic          s_tuser,   // operation
    input  logic          s_tlast,   // last_source
    output q_item_t       q_item,
    output logic          q_valid,
    input  logic          q_ready
);

    q_item_t                 fifo_reg [2];
    logic                    wr_ptr_reg, rd_ptr_reg;
    logic [1:0]              count_reg;
    logic [INDEX_BITS-1:0]   tgt_idx_reg;
    logic [INDEX_BITS-1:0]   idx_in;
    q_item_t                 item_in;
    logic                    push, pop;

    assign idx_in = INDEX_BITS'(s_tdata[15:0]);

    always_comb begin
        item_in.last = s_tlast;
        for (int k = 0; k < 3; k++) begin
            item_in.pos[k] = s_tdata[16 + 64*k +: 64];
            item_in.vel[k] = s_tdata[208 + 64*k +: 64];
        end
        item_in.mass = s_tdata[462:400];
        if (!s_tuser)
            item_in.kind = KIND_LOAD;
        else if (idx_in == tgt_idx_reg)
            item_in.kind = KIND_SKIP;
        else
            item_in.kind = KIND_SRC;
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
            tgt_idx_reg <= '0;
        end else begin
            if (push) begin
                fifo_reg[wr_ptr_reg] <= item_in;
                wr_ptr_reg           <= ~wr_ptr_reg;
                if (!s_tuser)
                    tgt_idx_reg <= idx_in;
            end
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/core/nbfj_fmul.sv =====
// Shared Q16.47 multiplier: four 32x32 partial products over successive
// cycles, sign correction, floor shift and saturation. Depends on nbfj_pkg.
module nbfj_fmul
    import nbfj_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [WORD_W-1:0]  a,
    input  logic [WORD_W-1:0]  b,
    output logic               done,
    output logic [WORD_W-1:0]  y
);

    logic [WORD_W-1:0]    a_reg, b_reg, pp_reg, y_reg;
    logic [1:0]           pps_reg;
    logic [127:0]         acc_reg, addend, shv;
    logic [3:0]           cnt_reg;
    logic                 run_reg, done_reg;
    logic [31:0]          ma, mb;
    logic [WORD_W-1:0]    pp_next, y_sat;
    logic [64:0]          top;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0: begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
            2'd1: begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            2'd2: begin ma = a_reg[63:32]; mb = b_reg[31:0];  end
            default: begin ma = a_reg[63:32]; mb = b_reg[63:32]; end
        endcase
        pp_next = {32'b0, ma} * {32'b0, mb};
        unique case (pps_reg)
            2'd0:    addend = {64'b0, pp_reg};
            2'd3:    addend = {pp_reg, 64'b0};
            default: addend = {32'b0, pp_reg, 32'b0};
        endcase
        shv = $signed(acc_reg) >>> FRAC_BITS;
        top = shv[127:63];
        if (top == '0 || top == '1)
            y_sat = shv[63:0];
        else
            y_sat = acc_reg[127] ? PAT_MIN : PAT_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg   <= a;
                b_reg   <= b;
                acc_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (cnt_reg <= 4'd3) begin
                    pp_reg  <= pp_next;
                    pps_reg <= cnt_reg[1:0];
                end
                if (cnt_reg >= 4'd1 && cnt_reg <= 4'd4)
                    acc_reg <= acc_reg + addend;
                // signed correction of the unsigned product, one term a cycle
                if (cnt_reg == 4'd5 && a_reg[63])
                    acc_reg[127:64] <= acc_reg[127:64] - b_reg;
                if (cnt_reg == 4'd6 && b_reg[63])
                    acc_reg[127:64] <= acc_reg[127:64] - a_reg;
                if (cnt_reg == 4'd7) begin
                    y_reg    <= y_sat;
                    done_reg <= 1'b1;
                    run_reg  <= 1'b0;
                end
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

// ===== rtl/core/nbfj_rsqrt.sv =====
// Inverse square root, floor(1/sqrt(d)) in Q16.47: restoring division of
// 2^141 by d, one bit a cycle, then a radix-4 integer root. Uses nbfj_pkg.
module nbfj_rsqrt
    import nbfj_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [WORD_W-1:0]  d,
    output logic               done,
    output logic [WORD_W-1:0]  y
);

    localparam logic [7:0] DIV_TOP  = 8'd141;
    localparam logic [7:0] ROOT_TOP = 8'd62;

    typedef enum logic [1:0] { R_IDLE, R_DIV, R_ROOT } rstate_t;

    rstate_t           state_reg;
    logic [7:0]        cnt_reg;
    logic [WORD_W-1:0] d_reg, rem_reg, y_reg;
    logic [125:0]      q_reg;
    logic [64:0]       srem_reg;
    logic [62:0]       root_reg;
    logic              done_reg;
    logic [64:0]       rem_sh;
    logic              qbit;
    logic [66:0]       srem_sh, trial;
    logic              rbit;

    always_comb begin
        rem_sh  = {rem_reg, (cnt_reg == DIV_TOP)};
        qbit    = (rem_sh >= {1'b0, d_reg});
        srem_sh = {srem_reg, q_reg[125:124]};
        trial   = {2'b0, root_reg, 2'b01};
        rbit    = (srem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE: begin
                    if (start) begin
                        if (d <= TINY_LIMIT) begin
                            y_reg    <= PAT_MAX;
                            done_reg <= 1'b1;
                        end else begin
                            d_reg     <= d;
                            rem_reg   <= '0;
                            q_reg     <= '0;
                            cnt_reg   <= DIV_TOP;
                            state_reg <= R_DIV;
                        end
                    end
                end
                R_DIV: begin
                    rem_reg <= qbit ? 64'(rem_sh - {1'b0, d_reg}) : rem_sh[63:0];
                    // quotient stays below 2^126 once d exceeds the tiny limit
                    q_reg   <= {q_reg[124:0], qbit};
                    if (cnt_reg == 8'd0) begin
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= ROOT_TOP;
                        state_reg <= R_ROOT;
                    end else begin
                        cnt_reg <= cnt_reg - 8'd1;
                    end
                end
                R_ROOT: begin
                    srem_reg <= rbit ? 65'(srem_sh - trial) : srem_sh[64:0];
                    root_reg <= {root_reg[61:0], rbit};
                    q_reg    <= {q_reg[123:0], 2'b00};
                    if (cnt_reg == 8'd0) begin
                        y_reg     <= {1'b0, root_reg[61:0], rbit};
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg - 8'd1;
                    end
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

// ===== rtl/core/nbfj_back.sv =====
// Back end: sequencer that runs one source interaction on the shared
// multiplier and inverse-root unit, keeps the sums and drives the result
// register. Depends on nbfj_pkg, nbfj_fmul, nbfj_rsqrt.
module nbfj_back
    import nbfj_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  q_item_t            q_item,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic [WORD_W-1:0]  eps,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [383:0]       m_tdata
);

    typedef enum logic [2:0] {
        B_IDLE, B_MUL_GO, B_MUL_WAIT, B_RSQ_GO, B_RSQ_WAIT, B_K3, B_EMIT
    } bstate_t;

    bstate_t           state_reg;
    logic [4:0]        step_reg;
    logic              last_reg, m_valid_reg;
    logic [383:0]      m_data_reg;
    logic [WORD_W-1:0] tpos_reg [3];
    logic [WORD_W-1:0] tvel_reg [3];
    logic [WORD_W-1:0] rr_reg [3];
    logic [WORD_W-1:0] vv_reg [3];
    logic [WORD_W-1:0] acc_reg [3];
    logic [WORD_W-1:0] jerk_reg [3];
    logic [WORD_W-1:0] mass_reg, d2_reg, rinv_reg, r2i_reg, r3i_reg, r5i_reg;
    logic [WORD_W-1:0] mr3_reg, mr5_reg, rv_reg, k3_reg, tmp_reg, t2_reg;
    logic [WORD_W-1:0] op_a, op_b, mul_y, rsq_y;
    logic              mul_done, rsq_done;

    nbfj_fmul u_fmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == B_MUL_GO),
        .a       (op_a),
        .b       (op_b),
        .done    (mul_done),
        .y       (mul_y)
    );

    nbfj_rsqrt u_rsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == B_RSQ_GO),
        .d       (d2_reg),
        .done    (rsq_done),
        .y       (rsq_y)
    );

    always_comb begin
        unique case (step_reg)
            5'd0:  begin op_a = rr_reg[0]; op_b = rr_reg[0]; end
            5'd1:  begin op_a = rr_reg[1]; op_b = rr_reg[1]; end
            5'd2:  begin op_a = rr_reg[2]; op_b = rr_reg[2]; end
            5'd3:  begin op_a = eps;       op_b = eps;       end
            5'd4:  begin op_a = rinv_reg;  op_b = rinv_reg;  end
            5'd5:  begin op_a = r2i_reg;   op_b = rinv_reg;  end
            5'd6:  begin op_a = r2i_reg;   op_b = r3i_reg;   end
            5'd7:  begin op_a = r3i_reg;   op_b = mass_reg;  end
            5'd8:  begin op_a = r5i_reg;   op_b = mass_reg;  end
            5'd9:  begin op_a = rr_reg[0]; op_b = vv_reg[0]; end
            5'd10: begin op_a = rr_reg[1]; op_b = vv_reg[1]; end
            5'd11: begin op_a = rr_reg[2]; op_b = vv_reg[2]; end
            5'd12: begin op_a = rr_reg[0]; op_b = mr3_reg;   end
            5'd13: begin op_a = vv_reg[0]; op_b = mr3_reg;   end
            5'd14: begin op_a = k3_reg;    op_b = rr_reg[0]; end
            5'd16: begin op_a = rr_reg[1]; op_b = mr3_reg;   end
            5'd17: begin op_a = vv_reg[1]; op_b = mr3_reg;   end
            5'd18: begin op_a = k3_reg;    op_b = rr_reg[1]; end
            5'd20: begin op_a = rr_reg[2]; op_b = mr3_reg;   end
            5'd21: begin op_a = vv_reg[2]; op_b = mr3_reg;   end
            5'd22: begin op_a = k3_reg;    op_b = rr_reg[2]; end
            5'd15, 5'd19, 5'd23: begin op_a = t2_reg; op_b = mr5_reg; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign q_ready  = (state_reg == B_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                tpos_reg[k] <= '0;
                tvel_reg[k] <= '0;
                acc_reg[k]  <= '0;
                jerk_reg[k] <= '0;
            end
        end else begin
            // B_EMIT reloads the result register itself
            if (m_valid_reg && m_tready && state_reg != B_EMIT)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        last_reg <= q_item.last;
                        unique case (q_item.kind)
                            KIND_LOAD: begin
                                for (int k = 0; k < 3; k++) begin
                                    tpos_reg[k] <= q_item.pos[k];
                                    tvel_reg[k] <= q_item.vel[k];
                                    acc_reg[k]  <= '0;
                                    jerk_reg[k] <= '0;
                                end
                            end
                            KIND_SRC: begin
                                for (int k = 0; k < 3; k++) begin
                                    rr_reg[k] <= sat_sub(q_item.pos[k], tpos_reg[k]);
                                    vv_reg[k] <= sat_sub(q_item.vel[k], tvel_reg[k]);
                                end
                                mass_reg  <= {1'b0, q_item.mass};
                                step_reg  <= '0;
                                state_reg <= B_MUL_GO;
                            end
                            KIND_SKIP: begin
                                if (q_item.last)
                                    state_reg <= B_EMIT;
                            end
                            default: state_reg <= B_IDLE;
                        endcase
                    end
                end
                B_MUL_GO: state_reg <= B_MUL_WAIT;
                B_MUL_WAIT: begin
                    if (mul_done) begin
                        unique case (step_reg)
                            5'd0:  d2_reg <= mul_y;
                            5'd1, 5'd2, 5'd3: d2_reg <= sat_add(d2_reg, mul_y);
                            5'd4:  r2i_reg <= mul_y;
                            5'd5:  r3i_reg <= mul_y;
                            5'd6:  r5i_reg <= mul_y;
                            5'd7:  mr3_reg <= mul_y;
                            5'd8:  mr5_reg <= mul_y;
                            5'd9:  rv_reg <= mul_y;
                            5'd10, 5'd11: rv_reg <= sat_add(rv_reg, mul_y);
                            5'd12: acc_reg[0] <= sat_add(acc_reg[0], mul_y);
                            5'd16: acc_reg[1] <= sat_add(acc_reg[1], mul_y);
                            5'd20: acc_reg[2] <= sat_add(acc_reg[2], mul_y);
                            5'd13, 5'd17, 5'd21: tmp_reg <= mul_y;
                            5'd14, 5'd18, 5'd22: t2_reg <= mul_y;
                            5'd15: jerk_reg[0] <= sat_add(jerk_reg[0],
                                                          sat_sub(tmp_reg, mul_y));
                            5'd19: jerk_reg[1] <= sat_add(jerk_reg[1],
                                                          sat_sub(tmp_reg, mul_y));
                            5'd23: jerk_reg[2] <= sat_add(jerk_reg[2],
                                                          sat_sub(tmp_reg, mul_y));
                            default: d2_reg <= d2_reg;
                        endcase
                        priority if (step_reg == 5'd3) begin
                            state_reg <= B_RSQ_GO;
                        end else if (step_reg == 5'd11) begin
                            state_reg <= B_K3;
                        end else if (step_reg == 5'd23) begin
                            state_reg <= last_reg ? B_EMIT : B_IDLE;
                        end else begin
                            step_reg  <= step_reg + 5'd1;
                            state_reg <= B_MUL_GO;
                        end
                    end
                end
                B_RSQ_GO: state_reg <= B_RSQ_WAIT;
                B_RSQ_WAIT: begin
                    if (rsq_done) begin
                        rinv_reg  <= rsq_y;
                        step_reg  <= 5'd4;
                        state_reg <= B_MUL_GO;
                    end
                end
                B_K3: begin
                    k3_reg    <= sat_add(sat_add(rv_reg, rv_reg), rv_reg);
                    step_reg  <= 5'd12;
                    state_reg <= B_MUL_GO;
                end
                B_EMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= {jerk_reg[2], jerk_reg[1], jerk_reg[0],
                                        acc_reg[2], acc_reg[1], acc_reg[0]};
                        m_valid_reg <= 1'b1;
                        state_reg   <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/nbody_force_jerk_pipeline.sv =====
// Softened gravity acceleration and jerk on one target particle, Q16.47.
// Load items set the target and clear the sums; each source item runs the
// shared inverse-root unit (142 division steps plus 63 root steps) and 24
// products on one multiplier. When the squared distance is at or below the
// tiny limit the division and root are skipped. Loads and self-interaction
// items are taken in the idle state with no products. A two-entry queue
// sits between the front and the sequencer; the result register frees the
// sequencer while a result waits. The result follows the tlast source.
// Depends on nbfj_pkg, nbfj_front, nbfj_back.
module nbody_force_jerk_pipeline
    import nbfj_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [62:0]   cfg_data,    // softening_length
    input  logic          s_tvalid,
    output logic          s_tready,
    // particle_index[15:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    // mass[462:400], zero pad bit
    input  logic [463:0]  s_tdata,
    input  logic          s_tuser,     // operation
    input  logic          s_tlast,     // last_source
    output logic          m_tvalid,
    input  logic          m_tready,
    // acc_x, acc_y, acc_z, jerk_x, jerk_y, jerk_z, 64 bits each
    output logic [383:0]  m_tdata
);

    logic [MASS_W-1:0] soft_len_reg;
    q_item_t           q_item;
    logic              q_valid, q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            soft_len_reg <= '0;
        else if (cfg_valid && cfg_ready)
            soft_len_reg <= cfg_data;
    end

    nbfj_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready)
    );

    nbfj_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .eps      ({1'b0, soft_len_reg}),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/nbfj_checker.sv =====
// Port-level checks for the force/jerk block, bound to the top level.
// Depends on nothing but the top-level ports.
module nbfj_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          cfg_ready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [383:0]  m_tdata
);

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_cfg_open: assert property (@(posedge aclk)
        $past(aresetn) |-> cfg_ready)
        else $error("config channel not ready");

endmodule

bind nbody_force_jerk_pipeline nbfj_checker u_nbfj_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
